// ===== design/dstp_pkg.sv =====
// Shared types, codes and helpers of the timestamp pairing unit.
package dstp_pkg;

	localparam int STAMP_W     = 64;
	localparam int CNT_W       = 32;
	localparam int REF_PORT_W  = 16;
	localparam int TAG_PORT_W  = 16;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 32;
	localparam int MAX_RESULTS = 18;
	localparam int RES_CNT_W   = 5;

	localparam logic [STAMP_W-1:0] STAMP_MIN = {1'b1, {(STAMP_W-1){1'b0}}};

	localparam logic [CFG_IDX_W-1:0] CFG_PAIRING_MODE   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE_NS   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_UNMATCHED_MODE = 2'd2;

	typedef enum logic [1:0] {
		FUNC_LEFT  = 2'd0,
		FUNC_RIGHT = 2'd1,
		FUNC_FLUSH = 2'd2,
		FUNC_NOP   = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		KIND_PAIR    = 2'd0,
		KIND_DROP_L  = 2'd1,
		KIND_DROP_R  = 2'd2,
		KIND_SUMMARY = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ERR_NONE      = 3'd0,
		ERR_FRAME     = 3'd1,
		ERR_OVERFLOW  = 3'd2,
		ERR_UNMATCHED = 3'd3,
		ERR_FULL      = 3'd4,
		ERR_ORDER     = 3'd5
	} err_t;

	typedef enum logic [2:0] {
		ACT_NONE    = 3'd0,
		ACT_DROP_IN = 3'd1,
		ACT_PUSH    = 3'd2,
		ACT_DROP_LH = 3'd3,
		ACT_DROP_RH = 3'd4,
		ACT_PAIR_H  = 3'd5,
		ACT_PAIR_N  = 3'd6,
		ACT_SUMMARY = 3'd7
	} act_t;

	typedef struct packed {
		logic load_in;
		logic rd_heads;
		logic rd_next;
		logic mag1;
		logic mag2;
		logic release_last;
		act_t act;
		err_t err;
	} cmd_t;

	typedef struct packed {
		func_t func;
		logic  in_order;
		logic  full;
		logic  l_nz;
		logic  r_nz;
		logic  r_ge2;
		logic  nearest;
		logic  d1_zero;
		logic  neg1;
		logic  over1;
		logic  ovf1;
		logic  close2;
		logic  ovf2;
		logic  emit_ok;
		logic  out_free;
		logic  pend_valid;
	} stat_t;

	typedef struct packed {
		kind_t                 kind;
		logic [STAMP_W-1:0]    left_stamp;
		logic [STAMP_W-1:0]    right_stamp;
		logic [REF_PORT_W-1:0] left_ref;
		logic [REF_PORT_W-1:0] right_ref;
		logic [CNT_W-1:0]      pair_delta;
		logic [CNT_W-1:0]      matched_total;
		logic [CNT_W-1:0]      dropped_left_total;
		logic [CNT_W-1:0]      dropped_right_total;
		logic [CNT_W-1:0]      max_delta;
		err_t                  error_code;
	} res_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
		return (&c) ? c : c + CNT_W'(1);
	endfunction

endpackage

// ===== design/dual_stream_timestamp_pairing_unit.sv =====
// Top level of the dual-stream timestamp pairing unit.
//
// Left and right samples arrive on one valid/ready channel, tagged by func,
// and are queued per side in two RAMs of QUEUE_DEPTH entries. After each
// arrival the block pairs queued heads as far as it can (exact stamp match, or
// nearest within tolerance_ns), and a flush item pairs, drops every leftover
// sample (left first) and ends with a summary result before starting a new
// session. Results leave through an output register; the newest result of an
// item is held one stage back so that it can carry last when the item is
// done, and at most 18 results are given per item. Sequence: an item is taken
// only while the controller is idle, in its accept cycle; a sample item then
// passes the order/full check, and every pairing step runs through head read,
// capture and first difference, two magnitude stages and a decision, with a
// second decision state when the right head is dropped for a closer second
// entry. A final head read finds no pairable heads and a finish state
// releases the last result. A flush runs the same pairing steps, then drains
// queued samples one at a time (head read, capture, drop), finds both queues
// empty, emits the summary and releases it. A step that emits a result waits
// while the held result cannot move into a stalled output register.
module dual_stream_timestamp_pairing_unit #(
	parameter int QUEUE_DEPTH = 16,
	parameter int REF_WIDTH   = 16,
	parameter int TAG_WIDTH   = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dstp_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [dstp_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 in_valid,
	output logic                                 in_ready,
	input  logic [1:0]                           func,
	input  logic signed [dstp_pkg::STAMP_W-1:0]  stamp,
	input  logic [dstp_pkg::TAG_PORT_W-1:0]      frame_tag,
	input  logic [dstp_pkg::REF_PORT_W-1:0]      sample_ref,
	output logic                                 out_valid,
	input  logic                                 out_ready,
	output logic [1:0]                           kind,
	output logic signed [dstp_pkg::STAMP_W-1:0]  left_stamp,
	output logic signed [dstp_pkg::STAMP_W-1:0]  right_stamp,
	output logic [dstp_pkg::REF_PORT_W-1:0]      left_ref,
	output logic [dstp_pkg::REF_PORT_W-1:0]      right_ref,
	output logic [dstp_pkg::CNT_W-1:0]           pair_delta,
	output logic [dstp_pkg::CNT_W-1:0]           matched_total,
	output logic [dstp_pkg::CNT_W-1:0]           dropped_left_total,
	output logic [dstp_pkg::CNT_W-1:0]           dropped_right_total,
	output logic [dstp_pkg::CNT_W-1:0]           max_delta,
	output logic [2:0]                           error_code,
	output logic                                 last
);
	import dstp_pkg::*;

	cmd_t  cmd;
	stat_t stat;
	res_t  res;

	// controller: one-hot sequencer, never touches payload
	dstp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.func     (func),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// datapath: queues, differences, counters and result registers
	dstp_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.REF_WIDTH   (REF_WIDTH),
		.TAG_WIDTH   (TAG_WIDTH)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.func       (func),
		.stamp      (stamp),
		.frame_tag  (frame_tag),
		.sample_ref (sample_ref),
		.out_ready  (out_ready),
		.out_valid  (out_valid),
		.res        (res),
		.last       (last)
	);

	// unpack the registered result onto the output ports
	assign kind                = res.kind;
	assign left_stamp          = res.left_stamp;
	assign right_stamp         = res.right_stamp;
	assign left_ref            = res.left_ref;
	assign right_ref           = res.right_ref;
	assign pair_delta          = res.pair_delta;
	assign matched_total       = res.matched_total;
	assign dropped_left_total  = res.dropped_left_total;
	assign dropped_right_total = res.dropped_right_total;
	assign max_delta           = res.max_delta;
	assign error_code          = res.error_code;
endmodule

// ===== design/dstp_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dstp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;
endmodule

// ===== design/dstp_dp.sv =====
// Datapath: queues, stamp differences, counters, pending and output result registers.
module dstp_dp #(
	parameter int QUEUE_DEPTH = 16,
	parameter int REF_WIDTH   = 16,
	parameter int TAG_WIDTH   = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  dstp_pkg::cmd_t                        cmd,
	output dstp_pkg::stat_t                       stat,
	input  logic                                  cfg_we,
	input  logic [dstp_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  logic [dstp_pkg::CFG_DATA_W-1:0]       cfg_data,
	input  logic [1:0]                            func,
	input  logic signed [dstp_pkg::STAMP_W-1:0]   stamp,
	input  logic [dstp_pkg::TAG_PORT_W-1:0]       frame_tag,
	input  logic [dstp_pkg::REF_PORT_W-1:0]       sample_ref,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output dstp_pkg::res_t                        res,
	output logic                                  last
);
	import dstp_pkg::*;

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int EW = STAMP_W + TAG_WIDTH + REF_WIDTH;

	// input item
	func_t                     in_func_q;
	logic signed [STAMP_W-1:0] in_stamp_q;
	logic [TAG_WIDTH-1:0]      in_tag_q;
	logic [REF_WIDTH-1:0]      in_ref_q;

	// configuration
	logic               mode_q;
	logic [CNT_W-1:0]   tol_q;
	logic               unm_q;

	// queue pointers and session state
	logic [AW-1:0]             lhead_q, rhead_q;
	logic [CW-1:0]             lcnt_q, rcnt_q;
	logic signed [STAMP_W-1:0] prev_l_q, prev_r_q;
	logic [CNT_W-1:0]          pair_cnt_q, ldrop_q, rdrop_q, maxd_q;
	err_t                      sticky_q;
	logic [RES_CNT_W-1:0]      res_n_q;

	// head entries and differences
	logic [EW-1:0]      lent_q, rent_q, r2ent_q;
	logic [STAMP_W:0]   d1_q, d2_q;
	logic [STAMP_W-1:0] m1_q, m2_q;

	// result registers
	res_t pend_q, out_q;
	logic pend_valid_q, out_valid_q, out_last_q;

	// RAM ports
	logic          l_we, r_we, l_re, r_re;
	logic [AW-1:0] waddr, l_raddr, r_raddr;
	logic [EW-1:0] wdata, l_rdata, r_rdata;

	function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
		return (i == AW'(QUEUE_DEPTH - 1)) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [STAMP_W-1:0] ent_stamp(input logic [EW-1:0] e);
		return e[EW-1 -: STAMP_W];
	endfunction

	function automatic logic [STAMP_W:0] sdiff(input logic [STAMP_W-1:0] a,
		input logic [STAMP_W-1:0] b);
		return {a[STAMP_W-1], a} - {b[STAMP_W-1], b};
	endfunction

	function automatic logic [STAMP_W-1:0] sabs(input logic [STAMP_W:0] d);
		logic [STAMP_W:0] n;
		n = -d;
		return d[STAMP_W] ? n[STAMP_W-1:0] : d[STAMP_W-1:0];
	endfunction

	logic          side_r;
	logic [AW-1:0] side_head;
	logic [CW-1:0] side_cnt;
	logic [AW:0]   psum;
	logic [AW-1:0] push_slot;

	assign side_r    = (in_func_q == FUNC_RIGHT);
	assign side_head = side_r ? rhead_q : lhead_q;
	assign side_cnt  = side_r ? rcnt_q : lcnt_q;
	assign psum      = {1'b0, side_head} + (AW+1)'(side_cnt);
	assign push_slot = (psum >= (AW+1)'(QUEUE_DEPTH)) ?
		AW'(psum - (AW+1)'(QUEUE_DEPTH)) : AW'(psum);

	assign waddr   = push_slot;
	assign wdata   = {in_stamp_q, in_tag_q, in_ref_q};
	assign l_we    = (cmd.act == ACT_PUSH) && !side_r;
	assign r_we    = (cmd.act == ACT_PUSH) && side_r;
	assign l_re    = cmd.rd_heads;
	assign r_re    = cmd.rd_heads || cmd.rd_next;
	assign l_raddr = lhead_q;
	assign r_raddr = cmd.rd_next ? idx_inc(rhead_q) : rhead_q;

	dstp_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_left_ram (
		.clk(clk), .we(l_we), .waddr(waddr), .wdata(wdata),
		.re(l_re), .raddr(l_raddr), .rdata(l_rdata)
	);

	dstp_ram #(.WIDTH(EW), .DEPTH(QUEUE_DEPTH)) u_right_ram (
		.clk(clk), .we(r_we), .waddr(waddr), .wdata(wdata),
		.re(r_re), .raddr(r_raddr), .rdata(r_rdata)
	);

	// status
	logic out_free;
	logic [STAMP_W-1:0] tol_ext;

	assign out_free = !out_valid_q || out_ready;
	assign tol_ext  = {{(STAMP_W-CNT_W){1'b0}}, tol_q};

	always_comb begin
		stat            = '0;
		stat.func       = in_func_q;
		stat.in_order   = !(in_stamp_q < (side_r ? prev_r_q : prev_l_q));
		stat.full       = (side_cnt == CW'(QUEUE_DEPTH));
		stat.l_nz       = (lcnt_q != '0);
		stat.r_nz       = (rcnt_q != '0);
		stat.r_ge2      = (rcnt_q >= CW'(2));
		stat.nearest    = mode_q;
		stat.d1_zero    = (d1_q == '0);
		stat.neg1       = d1_q[STAMP_W];
		stat.over1      = (m1_q > tol_ext);
		stat.ovf1       = d1_q[STAMP_W] ? (m1_q > STAMP_MIN) : m1_q[STAMP_W-1];
		stat.close2     = (m2_q <= tol_ext) && (m2_q < m1_q);
		stat.ovf2       = d2_q[STAMP_W] ? (m2_q > STAMP_MIN) : m2_q[STAMP_W-1];
		stat.emit_ok    = !pend_valid_q || out_free;
		stat.out_free   = out_free;
		stat.pend_valid = pend_valid_q;
	end

	// result of the current action
	res_t               new_res;
	err_t               err_v;
	logic [CNT_W-1:0]   pc_n, dl_n, dr_n, md_n;
	logic [EW-1:0]      pr_ent;
	logic [STAMP_W-1:0] pr_mag;
	logic               emit_act, emit;

	assign pr_ent = (cmd.act == ACT_PAIR_N) ? r2ent_q : rent_q;
	assign pr_mag = (cmd.act == ACT_PAIR_N) ? m2_q : m1_q;

	always_comb begin
		new_res  = '0;
		err_v    = cmd.err;
		pc_n     = pair_cnt_q;
		dl_n     = ldrop_q;
		dr_n     = rdrop_q;
		md_n     = maxd_q;
		emit_act = 1'b1;
		case (cmd.act)
			ACT_DROP_IN: begin
				if (side_r) begin
					dr_n                = sat_inc(rdrop_q);
					new_res.kind        = KIND_DROP_R;
					new_res.right_stamp = in_stamp_q;
					new_res.right_ref   = REF_PORT_W'(in_ref_q);
				end else begin
					dl_n               = sat_inc(ldrop_q);
					new_res.kind       = KIND_DROP_L;
					new_res.left_stamp = in_stamp_q;
					new_res.left_ref   = REF_PORT_W'(in_ref_q);
				end
			end
			ACT_DROP_LH: begin
				dl_n               = sat_inc(ldrop_q);
				new_res.kind       = KIND_DROP_L;
				new_res.left_stamp = ent_stamp(lent_q);
				new_res.left_ref   = REF_PORT_W'(lent_q[REF_WIDTH-1:0]);
			end
			ACT_DROP_RH: begin
				dr_n                = sat_inc(rdrop_q);
				new_res.kind        = KIND_DROP_R;
				new_res.right_stamp = ent_stamp(rent_q);
				new_res.right_ref   = REF_PORT_W'(rent_q[REF_WIDTH-1:0]);
			end
			ACT_PAIR_H, ACT_PAIR_N: begin
				if (err_v == ERR_NONE &&
					lent_q[REF_WIDTH +: TAG_WIDTH] != pr_ent[REF_WIDTH +: TAG_WIDTH]) begin
					err_v = ERR_FRAME;
				end
				if (err_v == ERR_NONE) begin
					pc_n = sat_inc(pair_cnt_q);
					if (pr_mag > {{(STAMP_W-CNT_W){1'b0}}, maxd_q}) begin
						md_n = pr_mag[CNT_W-1:0];
					end
				end
				new_res.kind        = KIND_PAIR;
				new_res.left_stamp  = ent_stamp(lent_q);
				new_res.right_stamp = ent_stamp(pr_ent);
				new_res.left_ref    = REF_PORT_W'(lent_q[REF_WIDTH-1:0]);
				new_res.right_ref   = REF_PORT_W'(pr_ent[REF_WIDTH-1:0]);
				new_res.pair_delta  = pr_mag[CNT_W-1:0];
			end
			ACT_SUMMARY: begin
				if (sticky_q != ERR_NONE) begin
					err_v = sticky_q;
				end else if (!unm_q && (ldrop_q != '0 || rdrop_q != '0)) begin
					err_v = ERR_UNMATCHED;
				end else begin
					err_v = ERR_NONE;
				end
				new_res.kind = KIND_SUMMARY;
			end
			default: begin
				emit_act = 1'b0;
			end
		endcase
		new_res.matched_total       = pc_n;
		new_res.dropped_left_total  = dl_n;
		new_res.dropped_right_total = dr_n;
		new_res.max_delta           = md_n;
		new_res.error_code          = err_v;
	end

	assign emit = emit_act && (res_n_q < RES_CNT_W'(MAX_RESULTS));

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			in_func_q  <= func_t'(func);
			in_stamp_q <= stamp;
			in_tag_q   <= TAG_WIDTH'(frame_tag);
			in_ref_q   <= REF_WIDTH'(sample_ref);
		end
		if (cmd.rd_next) begin
			lent_q <= l_rdata;
			rent_q <= r_rdata;
			d1_q   <= sdiff(ent_stamp(l_rdata), ent_stamp(r_rdata));
		end
		if (cmd.mag1) begin
			r2ent_q <= r_rdata;
			d2_q    <= sdiff(ent_stamp(lent_q), ent_stamp(r_rdata));
			m1_q    <= sabs(d1_q);
		end
		if (cmd.mag2) begin
			m2_q <= sabs(d2_q);
		end
		if (emit) begin
			pend_q <= new_res;
			if (pend_valid_q) begin
				out_q      <= pend_q;
				out_last_q <= 1'b0;
			end
		end else if (cmd.release_last) begin
			out_q      <= pend_q;
			out_last_q <= 1'b1;
		end
	end

	// control and session state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q       <= 1'b0;
			tol_q        <= '0;
			unm_q        <= 1'b0;
			lhead_q      <= '0;
			rhead_q      <= '0;
			lcnt_q       <= '0;
			rcnt_q       <= '0;
			prev_l_q     <= STAMP_MIN;
			prev_r_q     <= STAMP_MIN;
			pair_cnt_q   <= '0;
			ldrop_q      <= '0;
			rdrop_q      <= '0;
			maxd_q       <= '0;
			sticky_q     <= ERR_NONE;
			res_n_q      <= '0;
			pend_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_PAIRING_MODE:   mode_q <= cfg_data[0];
					CFG_TOLERANCE_NS:   tol_q  <= cfg_data;
					CFG_UNMATCHED_MODE: unm_q  <= cfg_data[0];
					default: ;
				endcase
			end

			if (cmd.act == ACT_SUMMARY) begin
				lhead_q    <= '0;
				rhead_q    <= '0;
				lcnt_q     <= '0;
				rcnt_q     <= '0;
				prev_l_q   <= STAMP_MIN;
				prev_r_q   <= STAMP_MIN;
				pair_cnt_q <= '0;
				ldrop_q    <= '0;
				rdrop_q    <= '0;
				maxd_q     <= '0;
				sticky_q   <= ERR_NONE;
			end else begin
				pair_cnt_q <= pc_n;
				ldrop_q    <= dl_n;
				rdrop_q    <= dr_n;
				maxd_q     <= md_n;
				if (emit && err_v != ERR_NONE && sticky_q == ERR_NONE) begin
					sticky_q <= err_v;
				end
				case (cmd.act)
					ACT_PUSH: begin
						if (side_r) begin
							rcnt_q   <= rcnt_q + CW'(1);
							prev_r_q <= in_stamp_q;
						end else begin
							lcnt_q   <= lcnt_q + CW'(1);
							prev_l_q <= in_stamp_q;
						end
					end
					ACT_DROP_IN: begin
						if (cmd.err == ERR_FULL) begin
							if (side_r) begin
								prev_r_q <= in_stamp_q;
							end else begin
								prev_l_q <= in_stamp_q;
							end
						end
					end
					ACT_DROP_LH: begin
						lhead_q <= idx_inc(lhead_q);
						lcnt_q  <= lcnt_q - CW'(1);
					end
					ACT_DROP_RH: begin
						rhead_q <= idx_inc(rhead_q);
						rcnt_q  <= rcnt_q - CW'(1);
					end
					ACT_PAIR_H, ACT_PAIR_N: begin
						lhead_q <= idx_inc(lhead_q);
						lcnt_q  <= lcnt_q - CW'(1);
						rhead_q <= idx_inc(rhead_q);
						rcnt_q  <= rcnt_q - CW'(1);
					end
					default: ;
				endcase
			end

			if (cmd.load_in) begin
				res_n_q <= '0;
			end else if (emit) begin
				res_n_q <= res_n_q + RES_CNT_W'(1);
			end

			if (emit) begin
				pend_valid_q <= 1'b1;
			end else if (cmd.release_last) begin
				pend_valid_q <= 1'b0;
			end

			if ((emit && pend_valid_q) || cmd.release_last) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign res       = out_q;
	assign last      = out_last_q;
endmodule

// ===== design/dstp_ctrl.sv =====
// Controller: sequences order check, pairing steps, flush drain and summary.
module dstp_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic [1:0]      func,
	output logic            in_ready,
	input  dstp_pkg::stat_t stat,
	output dstp_pkg::cmd_t  cmd
);
	import dstp_pkg::*;

	typedef enum logic [12:0] {
		S_IDLE    = 13'b0000000000001,
		S_CHK     = 13'b0000000000010,
		S_P_RD    = 13'b0000000000100,
		S_P_CAP   = 13'b0000000001000,
		S_P_M1    = 13'b0000000010000,
		S_P_M2    = 13'b0000000100000,
		S_P_DEC   = 13'b0000001000000,
		S_P_DEC2  = 13'b0000010000000,
		S_DR_RD   = 13'b0000100000000,
		S_DR_CAP  = 13'b0001000000000,
		S_DR_DROP = 13'b0010000000000,
		S_SUM     = 13'b0100000000000,
		S_FIN     = 13'b1000000000000
	} state_t;

	state_t state_q, state_d;
	logic   flush;

	assign flush    = (stat.func == FUNC_FLUSH);
	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					if (func == FUNC_FLUSH) begin
						state_d = S_P_RD;
					end else if (func != FUNC_NOP) begin
						state_d = S_CHK;
					end
				end
			end
			S_CHK: begin
				if (!stat.in_order) begin
					if (stat.emit_ok) begin
						cmd.act = ACT_DROP_IN;
						cmd.err = ERR_ORDER;
						state_d = S_P_RD;
					end
				end else if (stat.full) begin
					if (stat.emit_ok) begin
						cmd.act = ACT_DROP_IN;
						cmd.err = ERR_FULL;
						state_d = S_P_RD;
					end
				end else begin
					cmd.act = ACT_PUSH;
					state_d = S_P_RD;
				end
			end
			S_P_RD: begin
				if (stat.l_nz && stat.r_nz) begin
					cmd.rd_heads = 1'b1;
					state_d      = S_P_CAP;
				end else if (flush) begin
					state_d = S_DR_RD;
				end else begin
					state_d = S_FIN;
				end
			end
			S_P_CAP: begin
				cmd.rd_next = 1'b1;
				state_d     = S_P_M1;
			end
			S_P_M1: begin
				cmd.mag1 = 1'b1;
				state_d  = S_P_M2;
			end
			S_P_M2: begin
				cmd.mag2 = 1'b1;
				state_d  = S_P_DEC;
			end
			S_P_DEC: begin
				if (stat.nearest && !stat.over1 && !stat.r_ge2 && !flush) begin
					// wait for a second right sample before choosing
					state_d = S_FIN;
				end else if (stat.emit_ok) begin
					state_d = S_P_RD;
					if (!stat.nearest) begin
						if (stat.d1_zero) begin
							cmd.act = ACT_PAIR_H;
						end else if (stat.neg1) begin
							cmd.act = ACT_DROP_LH;
						end else begin
							cmd.act = ACT_DROP_RH;
						end
					end else if (stat.over1) begin
						cmd.act = stat.neg1 ? ACT_DROP_LH : ACT_DROP_RH;
						cmd.err = stat.ovf1 ? ERR_OVERFLOW : ERR_NONE;
					end else if (!stat.r_ge2) begin
						cmd.act = ACT_PAIR_H;
					end else if (stat.close2) begin
						cmd.act = ACT_DROP_RH;
						state_d = S_P_DEC2;
					end else begin
						cmd.act = ACT_PAIR_H;
						cmd.err = stat.ovf2 ? ERR_OVERFLOW : ERR_NONE;
					end
				end
			end
			S_P_DEC2: begin
				if (stat.emit_ok) begin
					cmd.act = ACT_PAIR_N;
					state_d = S_P_RD;
				end
			end
			S_DR_RD: begin
				if (stat.l_nz || stat.r_nz) begin
					cmd.rd_heads = 1'b1;
					state_d      = S_DR_CAP;
				end else begin
					state_d = S_SUM;
				end
			end
			S_DR_CAP: begin
				cmd.rd_next = 1'b1;
				state_d     = S_DR_DROP;
			end
			S_DR_DROP: begin
				if (stat.emit_ok) begin
					cmd.act = stat.l_nz ? ACT_DROP_LH : ACT_DROP_RH;
					state_d = S_DR_RD;
				end
			end
			S_SUM: begin
				if (stat.emit_ok) begin
					cmd.act = ACT_SUMMARY;
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!stat.pend_valid) begin
					state_d = S_IDLE;
				end else if (stat.out_free) begin
					cmd.release_last = 1'b1;
					state_d          = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end
endmodule

// ===== sim/tb_top.sv =====
// Testbench of the dual-stream timestamp pairing unit: directed rows, then random sessions.
module tb_top;
	import dstp_pkg::*;

	localparam int DEPTH       = 16;
	localparam int SETTLE      = 300;     // cycles to let a silent item finish
	localparam int CYCLE_LIMIT = 600000;
	localparam int PHASE_ITEMS = 80;

	localparam logic [CFG_IDX_W-1:0] CFG_BEYOND_LIST = 2'd3;

	// one sample held in a side queue of the predictor
	typedef struct packed {
		logic signed [STAMP_W-1:0] stamp;
		logic [TAG_PORT_W-1:0]     tag;
		logic [REF_PORT_W-1:0]     sref;
	} held_sample_t;

	typedef struct packed {
		kind_t              kind;
		logic [STAMP_W-1:0] ls;
		logic [STAMP_W-1:0] rs;
		logic [15:0]        lref;
		logic [15:0]        rref;
		logic [31:0]        delta;
		logic [31:0]        matched;
		logic [31:0]        left_drops;
		logic [31:0]        right_drops;
		logic [31:0]        maxd;
		err_t               err;
		logic               last;
	} pairing_result_t;

	typedef struct packed {
		logic [STAMP_W-1:0] mag;
		logic               neg;
		logic               ovf;
	} stamp_gap_t;

	typedef struct {
		logic                      is_cfg;
		logic [CFG_IDX_W-1:0]      idx;
		logic [CFG_DATA_W-1:0]     data;
		func_t                     fn;
		logic signed [STAMP_W-1:0] st;
		logic [15:0]               tag;
		logic [15:0]               sref;
		logic                      typed;
		int                        typed_cnt;
		pairing_result_t           typed_res;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [1:0] func = '0;
	logic signed [STAMP_W-1:0] stamp = '0;
	logic [15:0] frame_tag = '0;
	logic [15:0] sample_ref = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] kind;
	logic signed [STAMP_W-1:0] left_stamp, right_stamp;
	logic [15:0] left_ref, right_ref;
	logic [31:0] pair_delta, matched_total, dropped_left_total, dropped_right_total, max_delta;
	logic [2:0] error_code;
	logic last;

	dual_stream_timestamp_pairing_unit dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor state
	held_sample_t left_q[$], right_q[$];
	logic [31:0] pairs_cnt, ldrop_cnt, rdrop_cnt, widest_gap;
	logic signed [STAMP_W-1:0] prev_stamp[2];
	err_t first_err;
	logic nearest_mode, drop_quietly;
	logic [31:0] tol;

	pairing_result_t item_results[$];
	pairing_result_t expected_results[$];
	stim_row_t dir_rows[$];

	int idle_pct = 0;
	int stall_pct = 0;
	int mismatches = 0;
	int cycle_count = 0;
	int items_sent = 0;

	function automatic logic [31:0] bump(logic [31:0] c);
		return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
	endfunction

	// magnitude of a - b, sign, and signed 64-bit overflow
	function automatic stamp_gap_t stamp_gap(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] d;
		logic [64:0] m;
		stamp_gap_t g;
		d = {a[63], a} - {b[63], b};
		g.neg = d[64];
		m = g.neg ? -d : d;
		g.mag = m[63:0];
		g.ovf = g.neg ? (m > {2'b01, 63'd0}) : (m[64:63] != 2'b00);
		return g;
	endfunction

	function automatic void emit_result(kind_t k, logic [63:0] ls, logic [63:0] rs,
			logic [15:0] lr, logic [15:0] rr, logic [31:0] dl, err_t e);
		pairing_result_t r;
		if (item_results.size() >= MAX_RESULTS)
			return;
		r = '{k, ls, rs, lr, rr, dl, pairs_cnt, ldrop_cnt, rdrop_cnt, widest_gap, e, 1'b0};
		item_results.insert(item_results.size(), r);
		if (e != ERR_NONE && first_err == ERR_NONE)
			first_err = e;
	endfunction

	function automatic void drop_sample(bit right, held_sample_t s, err_t e);
		if (right) begin
			rdrop_cnt = bump(rdrop_cnt);
			emit_result(KIND_DROP_R, '0, s.stamp, '0, s.sref, '0, e);
		end else begin
			ldrop_cnt = bump(ldrop_cnt);
			emit_result(KIND_DROP_L, s.stamp, '0, s.sref, '0, '0, e);
		end
	endfunction

	function automatic void pair_heads(logic [63:0] mag, err_t e);
		held_sample_t l, r;
		l = left_q.pop_front();
		r = right_q.pop_front();
		if (e == ERR_NONE && l.tag != r.tag)
			e = ERR_FRAME;
		if (e == ERR_NONE) begin
			pairs_cnt = bump(pairs_cnt);
			if (mag > {32'd0, widest_gap})
				widest_gap = mag[31:0];
		end
		emit_result(KIND_PAIR, l.stamp, r.stamp, l.sref, r.sref, mag[31:0], e);
	endfunction

	function automatic void pair_queued(bit flushing);
		stamp_gap_t g1, g2;
		while (left_q.size() > 0 && right_q.size() > 0) begin
			if (!nearest_mode) begin
				if (left_q[0].stamp == right_q[0].stamp)
					pair_heads('0, ERR_NONE);
				else if (left_q[0].stamp < right_q[0].stamp)
					drop_sample(0, left_q.pop_front(), ERR_NONE);
				else
					drop_sample(1, right_q.pop_front(), ERR_NONE);
				continue;
			end
			g1 = stamp_gap(left_q[0].stamp, right_q[0].stamp);
			if (g1.mag > {32'd0, tol}) begin
				// the older head cannot pair any more
				if (g1.neg)
					drop_sample(0, left_q.pop_front(), g1.ovf ? ERR_OVERFLOW : ERR_NONE);
				else
					drop_sample(1, right_q.pop_front(), g1.ovf ? ERR_OVERFLOW : ERR_NONE);
				continue;
			end
			if (right_q.size() < 2) begin
				if (!flushing)
					break;
				pair_heads(g1.mag, ERR_NONE);
				continue;
			end
			g2 = stamp_gap(left_q[0].stamp, right_q[1].stamp);
			if (g2.mag <= {32'd0, tol} && g2.mag < g1.mag) begin
				drop_sample(1, right_q.pop_front(), ERR_NONE);
				pair_heads(g2.mag, ERR_NONE);
			end else begin
				pair_heads(g1.mag, g2.ovf ? ERR_OVERFLOW : ERR_NONE);
			end
		end
	endfunction

	function automatic void clear_session();
		left_q.delete();
		right_q.delete();
		pairs_cnt = '0;
		ldrop_cnt = '0;
		rdrop_cnt = '0;
		widest_gap = '0;
		prev_stamp[0] = STAMP_MIN;
		prev_stamp[1] = STAMP_MIN;
		first_err = ERR_NONE;
	endfunction

	function automatic void predict_pairing(func_t f, logic signed [63:0] s, logic [15:0] t,
			logic [15:0] r);
		held_sample_t smp;
		err_t e;
		bit side;
		item_results.delete();
		if (f == FUNC_NOP)
			return;
		if (f == FUNC_FLUSH) begin
			pair_queued(1);
			while (left_q.size() > 0)
				drop_sample(0, left_q.pop_front(), ERR_NONE);
			while (right_q.size() > 0)
				drop_sample(1, right_q.pop_front(), ERR_NONE);
			e = first_err;
			if (e == ERR_NONE && !drop_quietly && (ldrop_cnt != 0 || rdrop_cnt != 0))
				e = ERR_UNMATCHED;
			emit_result(KIND_SUMMARY, '0, '0, '0, '0, '0, e);
			clear_session();
		end else begin
			side = (f == FUNC_RIGHT);
			smp = '{s, t, r};
			if (s < prev_stamp[side]) begin
				drop_sample(side, smp, ERR_ORDER);
			end else begin
				prev_stamp[side] = s;
				if ((side ? right_q.size() : left_q.size()) >= DEPTH)
					drop_sample(side, smp, ERR_FULL);
				else if (side)
					right_q.insert(right_q.size(), smp);
				else
					left_q.insert(left_q.size(), smp);
			end
			pair_queued(0);
		end
		if (item_results.size() > 0)
			item_results[item_results.size()-1].last = 1'b1;
	endfunction

	// move the results of the item just taken into the expected store
	function automatic void queue_expected();
		foreach (item_results[k])
			expected_results.insert(expected_results.size(), item_results[k]);
	endfunction

	function automatic void add_row(stim_row_t r);
		dir_rows.insert(dir_rows.size(), r);
	endfunction

	// receiver: stall at the phase's rate
	always @(posedge clk)
		out_ready <= ($urandom_range(0, 99) >= stall_pct);

	// abort on a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// compare every taken result with the oldest expectation
	always @(posedge clk) begin
		pairing_result_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got = '{kind_t'(kind), left_stamp, right_stamp, left_ref, right_ref, pair_delta,
				matched_total, dropped_left_total, dropped_right_total, max_delta,
				err_t'(error_code), last};
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result kind=%0d err=%0d", kind, error_code);
			end else begin
				want = expected_results.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("mismatch exp: k=%0d ls=%h rs=%h lr=%h rr=%h d=%h m=%h dl=%h dr=%h mx=%h e=%0d l=%b",
							want.kind, want.ls, want.rs, want.lref, want.rref, want.delta,
							want.matched, want.left_drops, want.right_drops, want.maxd,
							want.err, want.last);
						$display("         got: k=%0d ls=%h rs=%h lr=%h rr=%h d=%h m=%h dl=%h dr=%h mx=%h e=%0d l=%b",
							got.kind, got.ls, got.rs, got.lref, got.rref, got.delta,
							got.matched, got.left_drops, got.right_drops, got.maxd,
							got.err, got.last);
					end
				end
			end
		end
	end

	// hold the item until taken, then predict what it should cause
	task automatic send_item(func_t f, logic signed [63:0] s, logic [15:0] t, logic [15:0] r);
		if ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		stamp <= s;
		frame_tag <= t;
		sample_ref <= r;
		do @(posedge clk); while (!in_ready);
		predict_pairing(f, s, t, r);
		if (f != FUNC_NOP)
			items_sent++;
	endtask

	task automatic send_predicted(func_t f, logic signed [63:0] s, logic [15:0] t,
			logic [15:0] r);
		send_item(f, s, t, r);
		queue_expected();
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] i, logic [CFG_DATA_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= i;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		case (i)
			CFG_PAIRING_MODE:   nearest_mode = d[0];
			CFG_TOLERANCE_NS:   tol = d;
			CFG_UNMATCHED_MODE: drop_quietly = d[0];
			default: ;
		endcase
	endtask

	task automatic configure(logic m, logic [31:0] t, logic u);
		wait_idle();
		write_reg(CFG_PAIRING_MODE, {31'd0, m});
		write_reg(CFG_TOLERANCE_NS, t);
		write_reg(CFG_UNMATCHED_MODE, {31'd0, u});
	endtask

	function automatic stim_row_t item_row(func_t f, logic signed [63:0] s, logic [15:0] t,
			logic [15:0] r);
		stim_row_t row;
		row = '{1'b0, '0, '0, f, s, t, r, 1'b0, 0, '0};
		return row;
	endfunction

	function automatic stim_row_t cfg_row(logic [CFG_IDX_W-1:0] i, logic [31:0] d);
		stim_row_t row;
		row = '{1'b1, i, d, FUNC_NOP, '0, '0, '0, 1'b0, 0, '0};
		return row;
	endfunction

	// random sessions: mostly sorted streams with random content, some noise
	task automatic random_session();
		logic signed [63:0] cur[2];
		logic signed [63:0] s;
		logic [15:0] tag;
		int len, pick, side, shape;
		shape = $urandom_range(0, 9);
		tag = 16'($urandom);
		if (shape == 0) begin
			// overrun the left queue
			s = {$urandom, $urandom} >>> 2;
			for (int k = 0; k < DEPTH + 2; k++)
				send_predicted(FUNC_LEFT, s + k, tag, 16'($urandom));
		end else if (shape == 1) begin
			len = $urandom_range(2, 8);
			for (int k = 0; k < len; k++)
				send_predicted(func_t'($urandom_range(0, 3)), {$urandom, $urandom},
					16'($urandom), 16'($urandom));
		end else begin
			cur[0] = {$urandom, $urandom};
			if ($urandom_range(0, 3) != 0)
				cur[0] = cur[0] >>> $urandom_range(1, 50);
			cur[1] = cur[0] + $signed($urandom_range(0, 40)) - 20;
			len = $urandom_range(2, 25);
			for (int k = 0; k < len; k++) begin
				side = $urandom_range(0, 1);
				pick = $urandom_range(0, 19);
				if (pick == 0) begin
					send_predicted(FUNC_NOP, {$urandom, $urandom}, 16'($urandom),
						16'($urandom));
				end else if (pick == 1) begin
					send_predicted(side ? FUNC_RIGHT : FUNC_LEFT,
						cur[side] - $urandom_range(1, 9), tag, 16'($urandom));
				end else begin
					cur[side] = cur[side] + $urandom_range(0, 60);
					send_predicted(side ? FUNC_RIGHT : FUNC_LEFT, cur[side],
						(pick == 2) ? 16'($urandom) : tag, 16'($urandom));
				end
			end
		end
		send_predicted(FUNC_FLUSH, {$urandom, $urandom}, 16'($urandom), 16'($urandom));
	endtask

	initial begin
		stim_row_t row;
		int phase_goal;
		clear_session();
		nearest_mode = 1'b0;
		drop_quietly = 1'b0;
		tol = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty flush right after reset: a clean summary
		row = item_row(FUNC_FLUSH, '0, '0, '0);
		row.typed = 1'b1;
		row.typed_cnt = 1;
		row.typed_res = '{KIND_SUMMARY, '0, '0, '0, '0, '0, '0, '0, '0, '0, ERR_NONE, 1'b1};
		add_row(row);
		row = item_row(FUNC_NOP, 64'sd7, 16'h1, 16'h1);
		row.typed = 1'b1;
		add_row(row);
		add_row(item_row(FUNC_LEFT, 64'sd5, 16'h1, 16'h0011));
		// left stamp going backward
		row = item_row(FUNC_LEFT, 64'sd4, 16'h1, 16'h0022);
		row.typed = 1'b1;
		row.typed_cnt = 1;
		row.typed_res = '{KIND_DROP_L, 64'd4, '0, 16'h0022, '0, '0, '0, 32'd1, '0, '0,
			ERR_ORDER, 1'b1};
		add_row(row);
		add_row(item_row(FUNC_RIGHT, 64'sd5, 16'h1, 16'hFFFF));
		add_row(item_row(FUNC_RIGHT, STAMP_MIN, 16'h0, 16'h0));
		add_row(item_row(FUNC_LEFT, 64'h7FFF_FFFF_FFFF_FFFF, 16'hFFFF, 16'h0));
		add_row(item_row(FUNC_RIGHT, 64'h7FFF_FFFF_FFFF_FFFF, 16'h0, 16'hFFFF));
		add_row(item_row(FUNC_FLUSH, '0, '0, '0));
		add_row(cfg_row(CFG_PAIRING_MODE, 32'd1));
		add_row(cfg_row(CFG_TOLERANCE_NS, 32'hFFFF_FFFF));
		add_row(cfg_row(CFG_UNMATCHED_MODE, 32'd1));
		// a far second right entry overflows the difference on the pair
		add_row(item_row(FUNC_LEFT, 64'h8000_0000_0000_000A, 16'h2, 16'h3));
		add_row(item_row(FUNC_RIGHT, 64'h8000_0000_0000_0014, 16'h2, 16'h4));
		add_row(item_row(FUNC_RIGHT, 64'h7FFF_FFFF_FFFF_FFFF, 16'h2, 16'h5));
		add_row(item_row(FUNC_FLUSH, '0, '0, '0));
		add_row(cfg_row(CFG_TOLERANCE_NS, 32'd50));
		// stale right head, then a closer second right entry
		add_row(item_row(FUNC_LEFT, 64'sd1000, 16'h9, 16'h6));
		add_row(item_row(FUNC_RIGHT, 64'sd900, 16'h9, 16'h7));
		add_row(item_row(FUNC_RIGHT, 64'sd990, 16'h9, 16'h8));
		add_row(item_row(FUNC_RIGHT, 64'sd1001, 16'h9, 16'h9));
		add_row(item_row(FUNC_LEFT, 64'sd2000, 16'h9, 16'hA));
		add_row(cfg_row(CFG_UNMATCHED_MODE, 32'd0));
		add_row(item_row(FUNC_FLUSH, '0, '0, '0));
		add_row(cfg_row(CFG_BEYOND_LIST, 32'd1));   // index past the register list

		foreach (dir_rows[i]) begin
			row = dir_rows[i];
			if (row.is_cfg) begin
				wait_idle();
				write_reg(row.idx, row.data);
			end else begin
				send_item(row.fn, row.st, row.tag, row.sref);
				if (row.typed) begin
					item_results.delete();
					if (row.typed_cnt != 0)
						item_results.insert(0, row.typed_res);
				end
				queue_expected();
			end
		end

		// random phases: no idling, sender idle, receiver stalling, both
		for (int p = 0; p < 4; p++) begin
			case (p)
				0: configure(1'b0, 32'd0, 1'b0);
				1: configure(1'b1, $urandom_range(0, 300), 1'b1);
				2: configure(1'b1, 32'hFFFF_FFFF, 1'b0);
				default: configure(1'b1, 32'd0, 1'($urandom_range(0, 1)));
			endcase
			idle_pct = (p == 1 || p == 3) ? ((p == 1) ? 70 : 37) : 0;
			stall_pct = (p == 2 || p == 3) ? ((p == 2) ? 70 : 37) : 0;
			phase_goal = items_sent + PHASE_ITEMS;
			while (items_sent < phase_goal)
				random_session();
		end

		wait_idle();
		if (mismatches == 0 && expected_results.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// ===== dual_stream_timestamp_pairing_unit.f =====
design/dstp_pkg.sv
design/dstp_ram.sv
design/dstp_dp.sv
design/dstp_ctrl.sv
design/dual_stream_timestamp_pairing_unit.sv
sim/tb_top.sv
